>>> hw/rtl/rau_pkg.sv
// Package for the rational arithmetic unit: payload types, codes and the microcode table.
package rau_pkg;

  localparam int unsigned DW   = 32;      // numerator width
  localparam int unsigned DENW = DW - 1;  // positive denominator width
  localparam int unsigned NW   = DW + 2;  // normalization operands carry a negated value
  localparam int unsigned KW   = 5;       // count of common factors of two
  localparam int unsigned CW   = 5;       // divider bit counter
  localparam int unsigned PCW  = 6;       // microcode address

  typedef enum logic [2:0] {
    ACT_NORM,
    ACT_NEG,
    ACT_RECIP,
    ACT_ADD,
    ACT_SUB,
    ACT_MUL,
    ACT_DIV,
    ACT_TRUNC
  } action_e;

  typedef enum logic [1:0] {
    ST_OK,
    ST_ZDEN,
    ST_OVF,
    ST_DIVZ
  } status_e;

  typedef struct packed {
    action_e                action;
    logic signed [DW-1:0]   a_num;
    logic signed [DW-1:0]   a_den;
    logic signed [DW-1:0]   b_num;
    logic        [DENW-1:0] b_den;
  } rau_in_t;

  typedef struct packed {
    logic signed [DW-1:0]   res_num;
    logic        [DENW-1:0] res_den;
    status_e                status;
  } rau_out_t;

  // Datapath operations of one microcode step.
  typedef enum logic [3:0] {
    U_NOP,
    U_FIXSIGN,
    U_CHK,
    U_GCD_START,
    U_DIV_NUM,
    U_DIV_DEN,
    U_STORE_DEN,
    U_SUM,
    U_LOAD_B,
    U_TRN_START,
    U_TRN_STORE,
    U_EMIT_OK,
    U_EMIT_ERR
  } uop_e;

  typedef enum logic [2:0] {
    NS_NONE,
    NS_AN_AD,
    NS_NEG_AN,
    NS_AD_AN,
    NS_NEG_BN,
    NS_BD_BN,
    NS_SUM_P3,
    NS_P1_P2
  } nsel_e;

  typedef enum logic [2:0] {
    MS_NONE,
    MS_AN_BD,
    MS_AD_BN,
    MS_AD_BD,
    MS_AN_BN
  } msel_e;

  typedef enum logic [1:0] {
    PS_NONE,
    PS_P1,
    PS_P2,
    PS_P3
  } pst_e;

  typedef enum logic [3:0] {
    J_NONE,
    J_ALWAYS,
    J_OVF,
    J_DZERO,
    J_PRE,
    J_GCD_BUSY,
    J_DIV_BUSY,
    J_BZERO,
    J_ADZERO,
    J_SUB
  } cond_e;

  typedef struct packed {
    uop_e               op;
    nsel_e              nsel;
    msel_e              msel;
    pst_e               pst;
    logic               set_pre;
    cond_e              cond;
    logic [PCW-1:0]     target;
    status_e            st;
  } ucw_t;

  // Microcode entry points.
  localparam logic [PCW-1:0] A_IDLE  = PCW'(0);
  localparam logic [PCW-1:0] A_NRM   = PCW'(1);
  localparam logic [PCW-1:0] A_NEG   = PCW'(2);
  localparam logic [PCW-1:0] A_RCP   = PCW'(3);
  localparam logic [PCW-1:0] A_SUB   = PCW'(4);
  localparam logic [PCW-1:0] A_DIV   = PCW'(5);
  localparam logic [PCW-1:0] A_TRN   = PCW'(7);
  localparam logic [PCW-1:0] A_NORM  = PCW'(12);
  localparam logic [PCW-1:0] A_ADD   = PCW'(22);
  localparam logic [PCW-1:0] A_MUL   = PCW'(29);
  localparam logic [PCW-1:0] A_PRE   = PCW'(34);
  localparam logic [PCW-1:0] A_FZDEN = PCW'(36);
  localparam logic [PCW-1:0] A_FOVF  = PCW'(37);
  localparam logic [PCW-1:0] A_FDIVZ = PCW'(38);

  function automatic logic [PCW-1:0] entry(input action_e act);
    logic [PCW-1:0] a;
    case (act)
      ACT_NORM:  a = A_NRM;
      ACT_NEG:   a = A_NEG;
      ACT_RECIP: a = A_RCP;
      ACT_ADD:   a = A_ADD;
      ACT_SUB:   a = A_SUB;
      ACT_MUL:   a = A_MUL;
      ACT_DIV:   a = A_DIV;
      ACT_TRUNC: a = A_TRN;
      default:   a = A_IDLE;
    endcase
    return a;
  endfunction

  function automatic ucw_t ucode(input logic [PCW-1:0] pc);
    ucw_t w;
    w = '{op: U_NOP, nsel: NS_NONE, msel: MS_NONE, pst: PS_NONE, set_pre: 1'b0,
          cond: J_NONE, target: A_IDLE, st: ST_OK};
    case (pc)
      A_IDLE: begin
        w.cond = J_ALWAYS;
      end
      A_NRM: begin
        w.nsel = NS_AN_AD; w.cond = J_ALWAYS; w.target = A_NORM;
      end
      A_NEG: begin
        w.nsel = NS_NEG_AN; w.cond = J_ALWAYS; w.target = A_NORM;
      end
      A_RCP: begin
        w.nsel = NS_AD_AN; w.cond = J_ALWAYS; w.target = A_NORM;
      end
      A_SUB: begin
        w.nsel = NS_NEG_BN; w.set_pre = 1'b1; w.cond = J_ALWAYS; w.target = A_NORM;
      end
      A_DIV: begin
        w.nsel = NS_BD_BN; w.set_pre = 1'b1; w.cond = J_BZERO; w.target = A_FDIVZ;
      end
      A_DIV + PCW'(1): begin
        w.cond = J_ALWAYS; w.target = A_NORM;
      end
      // Truncation: one signed division of a_num by a_den.
      A_TRN: begin
        w.op = U_TRN_START; w.cond = J_ADZERO; w.target = A_FZDEN;
      end
      A_TRN + PCW'(1): begin
        w.cond = J_DIV_BUSY; w.target = A_TRN + PCW'(1);
      end
      A_TRN + PCW'(2): begin
        w.op = U_TRN_STORE;
      end
      A_TRN + PCW'(3): begin
        w.cond = J_OVF; w.target = A_FOVF;
      end
      A_TRN + PCW'(4): begin
        w.op = U_EMIT_OK; w.cond = J_ALWAYS; w.target = A_IDLE;
      end
      // Normalization of n/d: sign fix, range check, gcd, two exact divisions.
      A_NORM: begin
        w.op = U_FIXSIGN; w.cond = J_DZERO; w.target = A_FZDEN;
      end
      A_NORM + PCW'(1): begin
        w.op = U_CHK;
      end
      A_NORM + PCW'(2): begin
        w.op = U_GCD_START; w.cond = J_OVF; w.target = A_FOVF;
      end
      A_NORM + PCW'(3): begin
        w.cond = J_GCD_BUSY; w.target = A_NORM + PCW'(3);
      end
      A_NORM + PCW'(4): begin
        w.op = U_DIV_NUM;
      end
      A_NORM + PCW'(5): begin
        w.cond = J_DIV_BUSY; w.target = A_NORM + PCW'(5);
      end
      A_NORM + PCW'(6): begin
        w.op = U_DIV_DEN;
      end
      A_NORM + PCW'(7): begin
        w.cond = J_DIV_BUSY; w.target = A_NORM + PCW'(7);
      end
      A_NORM + PCW'(8): begin
        w.op = U_STORE_DEN; w.cond = J_PRE; w.target = A_PRE;
      end
      A_NORM + PCW'(9): begin
        w.op = U_EMIT_OK; w.cond = J_ALWAYS; w.target = A_IDLE;
      end
      // Sum of fractions: three products, one sum, then normalization.
      A_ADD: begin
        w.msel = MS_AN_BD;
      end
      A_ADD + PCW'(1): begin
        w.msel = MS_AD_BN; w.pst = PS_P1;
      end
      A_ADD + PCW'(2): begin
        w.msel = MS_AD_BD; w.pst = PS_P2;
      end
      A_ADD + PCW'(3): begin
        w.pst = PS_P3;
      end
      A_ADD + PCW'(4): begin
        w.op = U_SUM;
      end
      A_ADD + PCW'(5): begin
        w.nsel = NS_SUM_P3; w.cond = J_OVF; w.target = A_FOVF;
      end
      A_ADD + PCW'(6): begin
        w.cond = J_ALWAYS; w.target = A_NORM;
      end
      // Product of fractions.
      A_MUL: begin
        w.msel = MS_AN_BN;
      end
      A_MUL + PCW'(1): begin
        w.msel = MS_AD_BD; w.pst = PS_P1;
      end
      A_MUL + PCW'(2): begin
        w.pst = PS_P2;
      end
      A_MUL + PCW'(3): begin
        w.nsel = NS_P1_P2; w.cond = J_OVF; w.target = A_FOVF;
      end
      A_MUL + PCW'(4): begin
        w.cond = J_ALWAYS; w.target = A_NORM;
      end
      // The prepared second operand of subtract or divide replaces b.
      A_PRE: begin
        w.op = U_LOAD_B; w.cond = J_SUB; w.target = A_ADD;
      end
      A_PRE + PCW'(1): begin
        w.cond = J_ALWAYS; w.target = A_MUL;
      end
      A_FZDEN: begin
        w.op = U_EMIT_ERR; w.st = ST_ZDEN; w.cond = J_ALWAYS; w.target = A_IDLE;
      end
      A_FOVF: begin
        w.op = U_EMIT_ERR; w.st = ST_OVF; w.cond = J_ALWAYS; w.target = A_IDLE;
      end
      A_FDIVZ: begin
        w.op = U_EMIT_ERR; w.st = ST_DIVZ; w.cond = J_ALWAYS; w.target = A_IDLE;
      end
      default: begin
        w.cond = J_ALWAYS; w.target = A_IDLE;
      end
    endcase
    return w;
  endfunction

endpackage

>>> hw/rtl/rational_arithmetic_unit.sv
// Truncation runs one restoring division. Normalize, negate and reciprocal run the binary gcd
// loop (one step a cycle) and two restoring divisions; add and multiply first form products
// and then normalize, and subtract and divide normalize twice.
// One item is in work at a time; the next is taken once the result sits in the output register.
// Reset (asynchronous, active low) returns the sequencer to idle and empties the output.
module rational_arithmetic_unit (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  rau_pkg::rau_in_t  in_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output rau_pkg::rau_out_t out_o
);
  import rau_pkg::*;

  logic [PCW-1:0]          pc_q, pc_d;
  ucw_t                    uw;
  logic                    in_acc, out_free, stall, jump, emit_fire;
  logic                    gcd_go, div_go, ovf_set;

  action_e                 action_q;
  logic signed [DW-1:0]    an_q, ad_q, bn_q;
  logic        [DENW-1:0]  bd_q;
  logic signed [NW-1:0]    n_q, d_q;
  logic signed [2*DW-1:0]  m_q;
  logic signed [DW-1:0]    p1_q, p2_q, p3_q;
  logic                    ovf_q, pre_q, sgn_q;
  logic signed [DW-1:0]    rnum_q;
  logic        [DENW-1:0]  rden_q;

  logic        [DENW-1:0]  u_q, v_q, g_q;
  logic        [KW-1:0]    k_q;
  logic                    gcd_busy_q;

  logic        [DW-1:0]    dq_q, rem_q, dsr_q;
  logic        [CW-1:0]    cnt_q;
  logic                    div_busy_q;

  rau_out_t                out_q;
  logic                    out_valid_q;

  logic signed [DW-1:0]    mx, my;
  logic                    m_ovf;
  logic signed [DW:0]      sum_w;
  logic                    s_ovf;
  logic        [NW-1:0]    n_abs;
  logic        [DENW-1:0]  magn;
  logic                    chk_bad;
  logic        [DW-1:0]    an_mag, ad_mag, div_dvd, div_dsr;
  logic        [DW+1:0]    trial;

  // Sequencer: step counter with conditional jumps.
  always_comb begin
    uw         = ucode(pc_q);
    in_ready_o = (pc_q == A_IDLE);
    in_acc     = in_valid_i && in_ready_o;
    out_free   = !out_valid_q || out_ready_i;
    stall      = (uw.op inside {U_EMIT_OK, U_EMIT_ERR}) && !out_free;
    emit_fire  = (uw.op inside {U_EMIT_OK, U_EMIT_ERR}) && out_free;
    case (uw.cond)
      J_NONE:     jump = 1'b0;
      J_ALWAYS:   jump = 1'b1;
      J_OVF:      jump = ovf_q;
      J_DZERO:    jump = (d_q == '0);
      J_PRE:      jump = pre_q;
      J_GCD_BUSY: jump = gcd_busy_q;
      J_DIV_BUSY: jump = div_busy_q;
      J_BZERO:    jump = (bn_q == '0);
      J_ADZERO:   jump = (ad_q == '0);
      J_SUB:      jump = (action_q == ACT_SUB);
      default:    jump = 1'b0;
    endcase
    if (pc_q == A_IDLE) begin
      pc_d = in_acc ? entry(in_i.action) : A_IDLE;
    end else if (stall) begin
      pc_d = pc_q;
    end else if (jump) begin
      pc_d = uw.target;
    end else begin
      pc_d = pc_q + PCW'(1);
    end
  end

  // Datapath helpers.
  always_comb begin
    case (uw.msel)
      MS_AN_BD: begin mx = an_q; my = DW'({1'b0, bd_q}); end
      MS_AD_BN: begin mx = ad_q; my = bn_q; end
      MS_AD_BD: begin mx = ad_q; my = DW'({1'b0, bd_q}); end
      MS_AN_BN: begin mx = an_q; my = bn_q; end
      default:  begin mx = an_q; my = bn_q; end
    endcase
    m_ovf   = !((&m_q[2*DW-1:DW-1]) || !(|m_q[2*DW-1:DW-1]));
    sum_w   = (DW+1)'(p1_q) + (DW+1)'(p2_q);
    s_ovf   = (sum_w[DW] != sum_w[DW-1]);
    n_abs   = n_q[NW-1] ? -n_q : n_q;
    magn    = n_abs[DENW-1:0];
    // After the sign fix d is positive; the most negative value is rejected too.
    chk_bad = (|n_abs[NW-1:DW-1]) || (|d_q[NW-1:DW-1]);
    an_mag  = an_q[DW-1] ? DW'(-an_q) : an_q;
    ad_mag  = ad_q[DW-1] ? DW'(-ad_q) : ad_q;
    case (uw.op)
      U_DIV_NUM: begin div_dvd = DW'({1'b0, magn}); div_dsr = DW'({1'b0, g_q}); end
      U_DIV_DEN: begin
        div_dvd = DW'({1'b0, d_q[DENW-1:0]});
        div_dsr = DW'({1'b0, g_q});
      end
      default:   begin div_dvd = an_mag; div_dsr = ad_mag; end
    endcase
    trial   = {1'b0, rem_q, dq_q[DW-1]} - {2'b00, dsr_q};
    gcd_go  = (uw.op == U_GCD_START) && !ovf_q;
    div_go  = uw.op inside {U_DIV_NUM, U_DIV_DEN, U_TRN_START};
    ovf_set = ((uw.pst != PS_NONE) && m_ovf) || ((uw.op == U_SUM) && s_ovf) ||
              ((uw.op == U_CHK) && chk_bad) ||
              ((uw.op == U_TRN_STORE) && !sgn_q && dq_q[DW-1]);
  end

  // Control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_q        <= A_IDLE;
      ovf_q       <= 1'b0;
      pre_q       <= 1'b0;
      gcd_busy_q  <= 1'b0;
      div_busy_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      pc_q <= pc_d;
      if (in_acc) begin
        ovf_q <= 1'b0;
        pre_q <= 1'b0;
      end else begin
        ovf_q <= ovf_q | ovf_set;
        if (uw.set_pre) begin
          pre_q <= 1'b1;
        end else if (uw.op == U_LOAD_B) begin
          pre_q <= 1'b0;
        end
      end
      if (gcd_go) begin
        gcd_busy_q <= 1'b1;
      end else if (gcd_busy_q && (u_q == '0)) begin
        gcd_busy_q <= 1'b0;
      end
      if (div_go) begin
        div_busy_q <= 1'b1;
      end else if (div_busy_q && (cnt_q == '0)) begin
        div_busy_q <= 1'b0;
      end
      if (emit_fire) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Operand, product and result registers.
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      action_q <= in_i.action;
      an_q     <= in_i.a_num;
      ad_q     <= in_i.a_den;
      bn_q     <= in_i.b_num;
      bd_q     <= in_i.b_den;
    end
    if (uw.op == U_LOAD_B) begin
      bn_q <= rnum_q;
      bd_q <= rden_q;
    end
    case (uw.nsel)
      NS_AN_AD:  begin n_q <= NW'(an_q);             d_q <= NW'(ad_q); end
      NS_NEG_AN: begin n_q <= -NW'(an_q);            d_q <= NW'(ad_q); end
      NS_AD_AN:  begin n_q <= NW'(ad_q);             d_q <= NW'(an_q); end
      NS_NEG_BN: begin n_q <= -NW'(bn_q);            d_q <= NW'({1'b0, bd_q}); end
      NS_BD_BN:  begin n_q <= NW'({1'b0, bd_q});     d_q <= NW'(bn_q); end
      NS_SUM_P3: begin n_q <= NW'(p1_q);             d_q <= NW'(p3_q); end
      NS_P1_P2:  begin n_q <= NW'(p1_q);             d_q <= NW'(p2_q); end
      default:   ;
    endcase
    if ((uw.op == U_FIXSIGN) && d_q[NW-1]) begin
      n_q <= -n_q;
      d_q <= -d_q;
    end
    if (uw.msel != MS_NONE) begin
      m_q <= (2*DW)'(mx) * (2*DW)'(my);
    end
    case (uw.pst)
      PS_P1:   p1_q <= m_q[DW-1:0];
      PS_P2:   p2_q <= m_q[DW-1:0];
      PS_P3:   p3_q <= m_q[DW-1:0];
      default: ;
    endcase
    if (uw.op == U_SUM) begin
      p1_q <= sum_w[DW-1:0];
    end
    if (uw.op == U_DIV_DEN) begin
      rnum_q <= sgn_q ? DW'(-dq_q) : dq_q;
    end
    if (uw.op == U_STORE_DEN) begin
      rden_q <= dq_q[DENW-1:0];
    end
    if (uw.op == U_TRN_STORE) begin
      rnum_q <= sgn_q ? DW'(-dq_q) : dq_q;
      rden_q <= DENW'(1);
    end
    if (uw.op == U_TRN_START) begin
      sgn_q <= an_q[DW-1] ^ ad_q[DW-1];
    end

    // Binary gcd, one step a cycle; u reaching zero leaves the gcd as v shifted left by k, stored in g.
    if (gcd_go) begin
      u_q   <= magn;
      v_q   <= d_q[DENW-1:0];
      k_q   <= '0;
      sgn_q <= n_q[NW-1];
    end else if (gcd_busy_q) begin
      if (u_q == '0) begin
        g_q <= v_q << k_q;
      end else if (!u_q[0] && !v_q[0]) begin
        u_q <= u_q >> 1;
        v_q <= v_q >> 1;
        k_q <= k_q + KW'(1);
      end else if (!u_q[0]) begin
        u_q <= u_q >> 1;
      end else if (!v_q[0]) begin
        v_q <= v_q >> 1;
      end else if (u_q >= v_q) begin
        u_q <= (u_q - v_q) >> 1;
      end else begin
        v_q <= (v_q - u_q) >> 1;
      end
    end

    // Restoring divider, one quotient bit a cycle.
    if (div_go) begin
      dq_q  <= div_dvd;
      rem_q <= '0;
      dsr_q <= div_dsr;
      cnt_q <= '1;
    end else if (div_busy_q) begin
      if (!trial[DW+1]) begin
        rem_q <= trial[DW-1:0];
        dq_q  <= {dq_q[DW-2:0], 1'b1};
      end else begin
        rem_q <= {rem_q[DW-2:0], dq_q[DW-1]};
        dq_q  <= {dq_q[DW-2:0], 1'b0};
      end
      cnt_q <= cnt_q - CW'(1);
    end

    if (emit_fire) begin
      if (uw.op == U_EMIT_OK) begin
        out_q.res_num <= rnum_q;
        out_q.res_den <= rden_q;
      end else begin
        out_q.res_num <= '0;
        out_q.res_den <= DENW'(1);
      end
      out_q.status <= uw.st;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_o       = out_q;

  a_ok_den_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (out_o.status == ST_OK)) |-> (out_o.res_den != '0))
    else $error("successful result carries a zero denominator");

  a_err_zero_one: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (out_o.status != ST_OK)) |->
      ((out_o.res_num == '0) && (out_o.res_den == DENW'(1))))
    else $error("error result does not read zero over one");

  a_gcd_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(gcd_busy_q) |-> (g_q != '0))
    else $error("gcd finished with zero");

  a_pre_action: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pre_q |-> ((action_q == ACT_SUB) || (action_q == ACT_DIV)))
    else $error("operand preparation pending for an action that has none");

endmodule
